// ===== rtl/gba_pkg.sv =====
// Package for the grouped bitmap id allocator: sizes, codes, FSM states
// and the structs passed between the controller and the top level.
// No dependencies.
package gba_pkg;

  // Sizing
  localparam int unsigned MAX_IDS    = 4096;
  localparam int unsigned MAX_GROUPS = 16;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned WORD_COUNT = (MAX_IDS + WORD_W - 1) / WORD_W;
  localparam int unsigned MIN_GROUP  = (MAX_IDS + MAX_GROUPS - 1) / MAX_GROUPS;
  localparam int unsigned FIRST_ID   = 11;

  localparam int unsigned ID_W      = 12;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned WADDR_W   = $clog2(WORD_COUNT);
  localparam int unsigned BIT_W     = $clog2(WORD_W);
  localparam int unsigned GIDX_W    = $clog2(MAX_GROUPS);
  localparam int unsigned BND_W     = $clog2(MAX_IDS * MAX_GROUPS) + 1;
  localparam int unsigned COUNT_MAX = (2 ** CNT_W) - 1;
  localparam int unsigned CFG_IDX_W = 1;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_ID_COUNT      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDS_PER_GROUP = 1'b1;

  // Reset values of the config registers
  localparam logic [CNT_W-1:0] ID_COUNT_RST      = CNT_W'(4096);
  localparam logic [CNT_W-1:0] IDS_PER_GROUP_RST = CNT_W'(1024);

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_SPACE     = 2'd1,
    ST_OUT_OF_RANGE = 2'd2,
    ST_NOT_ALLOC    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_UPD_RD,
    S_UPD_WR,
    S_GDIV,
    S_RL_RD,
    S_RL_WR,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] id_count;
    logic [CNT_W-1:0] ids_per_group;
  } cfg_t;

  typedef struct packed {
    logic               en;
    logic [WADDR_W-1:0] addr;
    logic [WORD_W-1:0]  data;
  } bm_wr_t;

  typedef struct packed {
    logic              en;
    logic [GIDX_W-1:0] addr;
    logic [CNT_W-1:0]  data;
  } gm_wr_t;

endpackage

// ===== rtl/gba_mem.sv =====
// Synchronous RAM, one write and one read port, read data registered.
// Per-entry valid bits cleared at reset: an unwritten entry reads as zero.
// Depends on nothing.
module gba_mem #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] q_r;
  logic             q_vld_r;

  // Storage array and read register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    q_r <= mem_r[rd_addr];
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      q_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = q_vld_r ? q_r : '0;

endmodule

// ===== rtl/gba_ctrl.sv =====
// Allocator controller: request FSM, group-full pass, bitmap word scan,
// read-modify-write of bitmap and group counters, result register.
// Depends on gba_pkg.
module gba_ctrl
  import gba_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [ID_W-1:0]    in_release_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ID_W-1:0]    out_granted_id,
  output logic [1:0]         out_status,
  output logic [CNT_W-1:0]   out_free_total,
  output logic [WADDR_W-1:0] bm_rd_addr,
  input  logic [WORD_W-1:0]  bm_rd_data,
  output bm_wr_t             bm_wr,
  output logic [GIDX_W-1:0]  gm_rd_addr,
  input  logic [CNT_W-1:0]   gm_rd_data,
  output gm_wr_t             gm_wr
);

  state_t state_r, state_nxt;

  logic                  out_valid_r;
  logic [CNT_W-1:0]      total_r;
  logic [ID_W-1:0]       out_granted_r;
  status_t               out_status_r;
  logic [CNT_W-1:0]      out_free_r;

  status_t               status_r;
  logic [ID_W-1:0]       granted_r;
  logic [ID_W-1:0]       pos_r;
  logic [WORD_W-1:0]     word_r;
  logic [GIDX_W:0]       pidx_r;
  logic [MAX_GROUPS-1:0] full_r;
  logic [WADDR_W:0]      iw_r;
  logic [WADDR_W-1:0]    pw_r;
  logic                  pvld_r;
  logic [GIDX_W-1:0]     g_r;
  logic [BND_W-1:0]      nb_r;

  // Effective configuration
  logic [CNT_W-1:0] n_eff, gs, limit, avail, free_cnt;
  logic             rid_bad;

  always_comb begin
    n_eff = (cfg.id_count > CNT_W'(MAX_IDS)) ? CNT_W'(MAX_IDS) : cfg.id_count;
    gs    = cfg.ids_per_group;
    if (gs < CNT_W'(MIN_GROUP)) gs = CNT_W'(MIN_GROUP);
    if (gs > CNT_W'(MAX_IDS))   gs = CNT_W'(MAX_IDS);
    limit = (n_eff == '0) ? '0 : n_eff - CNT_W'(1);
    avail = (n_eff > CNT_W'(FIRST_ID)) ? n_eff - CNT_W'(FIRST_ID) : '0;
    free_cnt = (avail > total_r) ? avail - total_r : '0;
    rid_bad = (in_release_id < ID_W'(FIRST_ID)) || ({1'b0, in_release_id} >= n_eff);
  end

  // Scan of the word returned by the bitmap RAM
  logic [WORD_W-1:0] usable, cand, low;
  logic [BIT_W-1:0]  hit_bit;
  logic [CNT_W-1:0]  hit_pos, word_end;
  logic [GIDX_W-1:0] hit_grp;
  logic              full_cur, full_next, last_word, scan_adv, div_adv;
  logic [GIDX_W:0]   prev_idx;

  always_comb begin
    logic [CNT_W-1:0] p;
    logic             fb;
    full_cur  = full_r[g_r];
    full_next = (g_r == GIDX_W'(MAX_GROUPS - 1)) ? 1'b1 : full_r[g_r + GIDX_W'(1)];
    for (int i = 0; i < WORD_W; i++) begin
      p  = {1'b0, pw_r, BIT_W'(i)};
      fb = ({(BND_W - CNT_W)'(0), p} < nb_r) ? full_cur : full_next;
      usable[i] = (p >= CNT_W'(FIRST_ID - 1)) && (p < limit) && !fb;
    end
    cand = usable & ~bm_rd_data;
    low  = cand & (~cand + WORD_W'(1));
    hit_bit = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (low[i]) hit_bit = hit_bit | BIT_W'(i);
    end
    hit_pos  = {1'b0, pw_r, hit_bit};
    hit_grp  = ({(BND_W - CNT_W)'(0), hit_pos} < nb_r) ? g_r : g_r + GIDX_W'(1);
    word_end = {({1'b0, pw_r} + (WADDR_W + 1)'(1)), BIT_W'(0)};
    last_word = (pw_r == WADDR_W'(WORD_COUNT - 1)) || (word_end >= limit);
    scan_adv  = ({(BND_W - CNT_W)'(0), word_end} >= nb_r)
                && (g_r != GIDX_W'(MAX_GROUPS - 1));
    div_adv   = ({(BND_W - ID_W)'(0), pos_r} >= nb_r)
                && (g_r != GIDX_W'(MAX_GROUPS - 1));
    prev_idx  = pidx_r - (GIDX_W + 1)'(1);
  end

  logic out_load;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_RELEASE) state_nxt = rid_bad ? S_FIN : S_GDIV;
          else                       state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (pidx_r == (GIDX_W + 1)'(MAX_GROUPS)) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (pvld_r && (cand != '0))  state_nxt = S_UPD_RD;
        else if (pvld_r && last_word) state_nxt = S_FIN;
      end
      S_UPD_RD: state_nxt = S_UPD_WR;
      S_UPD_WR: state_nxt = S_FIN;
      S_GDIV: begin
        if (!div_adv) state_nxt = S_RL_RD;
      end
      S_RL_RD: state_nxt = S_RL_WR;
      S_RL_WR: state_nxt = S_FIN;
      S_FIN: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // RAM controls and handshake outputs
  logic rl_set;
  assign rl_set = bm_rd_data[pos_r[BIT_W-1:0]];

  always_comb begin
    in_stall   = (state_r != S_IDLE);
    bm_rd_addr = (state_r == S_SCAN) ? iw_r[WADDR_W-1:0] : pos_r[ID_W-1:BIT_W];
    gm_rd_addr = (state_r == S_PREP) ? pidx_r[GIDX_W-1:0] : g_r;
    bm_wr.en   = 1'b0;
    bm_wr.addr = pos_r[ID_W-1:BIT_W];
    bm_wr.data = word_r;
    gm_wr.en   = 1'b0;
    gm_wr.addr = g_r;
    gm_wr.data = gm_rd_data;
    case (state_r)
      S_UPD_WR: begin
        bm_wr.en   = 1'b1;
        gm_wr.en   = 1'b1;
        gm_wr.data = (gm_rd_data == CNT_W'(COUNT_MAX)) ? gm_rd_data
                                                       : gm_rd_data + CNT_W'(1);
      end
      S_RL_WR: begin
        bm_wr.en   = rl_set;
        bm_wr.data = bm_rd_data & ~(WORD_W'(1) << pos_r[BIT_W-1:0]);
        gm_wr.en   = rl_set;
        gm_wr.data = (gm_rd_data == '0) ? '0 : gm_rd_data - CNT_W'(1);
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load)        out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (state_r == S_UPD_WR && total_r != CNT_W'(COUNT_MAX)) begin
        total_r <= total_r + CNT_W'(1);
      end else if (state_r == S_RL_WR && rl_set && total_r != '0) begin
        total_r <= total_r - CNT_W'(1);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        pidx_r    <= '0;
        pos_r     <= in_release_id - ID_W'(1);
        status_r  <= (in_cmd == CMD_RELEASE && rid_bad) ? ST_OUT_OF_RANGE : ST_OK;
        granted_r <= '0;
        g_r       <= '0;
        nb_r      <= BND_W'(gs);
      end
      S_PREP: begin
        // group-full flags, one counter read per cycle
        if (pidx_r != '0) full_r[prev_idx[GIDX_W-1:0]] <= (gm_rd_data >= gs);
        pidx_r <= pidx_r + (GIDX_W + 1)'(1);
        iw_r   <= '0;
        pvld_r <= 1'b0;
      end
      S_SCAN: begin
        if (iw_r != (WADDR_W + 1)'(WORD_COUNT)) iw_r <= iw_r + (WADDR_W + 1)'(1);
        pvld_r <= (iw_r != (WADDR_W + 1)'(WORD_COUNT));
        pw_r   <= iw_r[WADDR_W-1:0];
        if (pvld_r) begin
          if (cand != '0) begin
            pos_r  <= hit_pos[ID_W-1:0];
            g_r    <= hit_grp;
            word_r <= bm_rd_data | low;
          end else if (last_word) begin
            status_r <= ST_NO_SPACE;
          end else if (scan_adv) begin
            g_r  <= g_r + GIDX_W'(1);
            nb_r <= nb_r + BND_W'(gs);
          end
        end
      end
      S_UPD_WR: granted_r <= pos_r + ID_W'(1);
      S_GDIV: begin
        // walk group boundaries up to the released position
        if (div_adv) begin
          g_r  <= g_r + GIDX_W'(1);
          nb_r <= nb_r + BND_W'(gs);
        end
      end
      S_RL_WR: begin
        if (!rl_set) status_r <= ST_NOT_ALLOC;
      end
      S_FIN: begin
        if (out_load) begin
          out_granted_r <= granted_r;
          out_status_r  <= status_r;
          out_free_r    <= free_cnt;
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_granted_id = out_granted_r;
  assign out_status     = out_status_r;
  assign out_free_total = out_free_r;

  // Checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r != S_IDLE))
    else $error("accepted request did not start work");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finish state");

  a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_granted_r != '0) |->
      (out_status_r == ST_OK && out_granted_r >= ID_W'(FIRST_ID)))
    else $error("granted id below the first allocatable id");

  a_counter_follows_bitmap: assert property (@(posedge clk) disable iff (!rst_n)
    bm_wr.en |-> gm_wr.en)
    else $error("bitmap written without group counter update");

endmodule

// ===== rtl/grouped_bitmap_id_allocator_top.sv =====
// Top level of the grouped bitmap id allocator: config registers, bitmap
// and group counter RAMs, controller.
// Depends on gba_pkg, gba_mem, gba_ctrl.
//
//   channel  direction  handshake          payload
//   in_      request    valid / stall      cmd, release_id
//   out_     result     valid / stall      granted_id, status, free_total
//   cfg_     write      valid / ready      index, data
//
// Allocate: a pass over the group counter RAM builds group-full flags, then one
// bitmap word per cycle is scanned (128 words max), then an update read, an
// update write of bitmap and counter, and the finish step load the result.
// Release: a walk over group boundaries, then a bitmap and counter read and write,
// then the finish step; a release outside the valid id range goes straight to finish.
// Reset clears control, counters and RAM valid bits at once; no clearing pass.
// One request is in work at a time; a held result stalls only the finish step.
module grouped_bitmap_id_allocator_top
  import gba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [ID_W-1:0]      in_release_id,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ID_W-1:0]      out_granted_id,
  output logic [1:0]           out_status,
  output logic [CNT_W-1:0]     out_free_total,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  cfg_t cfg_r;

  // Config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.id_count      <= ID_COUNT_RST;
      cfg_r.ids_per_group <= IDS_PER_GROUP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ID_COUNT:      cfg_r.id_count      <= cfg_data;
        CFG_IDS_PER_GROUP: cfg_r.ids_per_group <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [WADDR_W-1:0] bm_rd_addr;
  logic [WORD_W-1:0]  bm_rd_data;
  bm_wr_t             bm_wr;
  logic [GIDX_W-1:0]  gm_rd_addr;
  logic [CNT_W-1:0]   gm_rd_data;
  gm_wr_t             gm_wr;

  // Usage bitmap
  gba_mem #(
    .WIDTH (WORD_W),
    .DEPTH (WORD_COUNT)
  ) u_bitmap (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (bm_rd_addr),
    .wr_en   (bm_wr.en),
    .wr_addr (bm_wr.addr),
    .wr_data (bm_wr.data),
    .rd_data (bm_rd_data)
  );

  // Per-group used counters
  gba_mem #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_GROUPS)
  ) u_group_cnt (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (gm_rd_addr),
    .wr_en   (gm_wr.en),
    .wr_addr (gm_wr.addr),
    .wr_data (gm_wr.data),
    .rd_data (gm_rd_data)
  );

  gba_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_release_id  (in_release_id),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_granted_id (out_granted_id),
    .out_status     (out_status),
    .out_free_total (out_free_total),
    .bm_rd_addr     (bm_rd_addr),
    .bm_rd_data     (bm_rd_data),
    .bm_wr          (bm_wr),
    .gm_rd_addr     (gm_rd_addr),
    .gm_rd_data     (gm_rd_data),
    .gm_wr          (gm_wr)
  );

endmodule
